// File: rtl/core/isf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isf_pkg
// Types and constants shared by the ISO SDU fragmenter modules.
// ----------------------------------------------------------------------------
package isf_pkg;

    localparam int HANDLE_W   = 12;
    localparam int MAXLEN_W   = 14;
    localparam int INTERVAL_W = 22;
    localparam int SDU_LEN_W  = 12;
    localparam int SEQ_W      = 16;
    localparam int ELAPSED_W  = 32;
    localparam int ADDR_W     = 4;

    // Register indexes on the configuration port
    localparam logic [1:0] REG_HANDLE   = 2'd0;
    localparam logic [1:0] REG_MAXLEN   = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;

    localparam logic [HANDLE_W-1:0]   HANDLE_RESET   = 12'd0;
    localparam logic [MAXLEN_W-1:0]   MAXLEN_RESET   = 14'd251;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 22'd5000;

    localparam logic [MAXLEN_W-1:0] MAXLEN_FLOOR  = 14'd5;
    localparam logic [MAXLEN_W-1:0] SDU_HDR_BYTES = 14'd4;

    // Packet-boundary flag codes
    localparam logic [1:0] PB_FIRST    = 2'd0;
    localparam logic [1:0] PB_CONT     = 2'd1;
    localparam logic [1:0] PB_COMPLETE = 2'd2;
    localparam logic [1:0] PB_LAST     = 2'd3;

    typedef struct packed {
        logic [HANDLE_W-1:0]   handle;
        logic [MAXLEN_W-1:0]   max_len;
        logic [INTERVAL_W-1:0] interval;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage
`default_nettype wire

// File: rtl/core/isf_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isf_if
// Valid/ready channels for SDU input bytes and packet output bytes.
// ----------------------------------------------------------------------------
interface isf_in_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data_byte;
    logic        sdu_start;
    logic [11:0] sdu_length;
    logic [31:0] elapsed_us;

    modport source (output valid, output data_byte, output sdu_start,
                    output sdu_length, output elapsed_us, input ready);
    modport sink   (input valid, input data_byte, input sdu_start,
                    input sdu_length, input elapsed_us, output ready);
endinterface

interface isf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       last_of_run;

    modport source (output valid, output out_byte, output packet_end,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input packet_end,
                    input last_of_run, output ready);
endinterface
`default_nettype wire

// File: rtl/core/isf_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isf_cfg
// APB register file: connection handle, buffer size and ISO interval.
// ----------------------------------------------------------------------------
module isf_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [isf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    output isf_pkg::cfg_t                   cfg
);

    isf_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.handle   <= isf_pkg::HANDLE_RESET;
            cfg_reg.max_len  <= isf_pkg::MAXLEN_RESET;
            cfg_reg.interval <= isf_pkg::INTERVAL_RESET;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                isf_pkg::REG_HANDLE:   cfg_reg.handle   <= pwdata[isf_pkg::HANDLE_W-1:0];
                isf_pkg::REG_MAXLEN:   cfg_reg.max_len  <= pwdata[isf_pkg::MAXLEN_W-1:0];
                isf_pkg::REG_INTERVAL: cfg_reg.interval <= pwdata[isf_pkg::INTERVAL_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            isf_pkg::REG_HANDLE:   prdata = {20'd0, cfg_reg.handle};
            isf_pkg::REG_MAXLEN:   prdata = {18'd0, cfg_reg.max_len};
            isf_pkg::REG_INTERVAL: prdata = {10'd0, cfg_reg.interval};
            default:               prdata = 32'd0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/core/isf_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// isf_div
// Restoring divider, one quotient bit per cycle, for the interval number.
// ----------------------------------------------------------------------------
module isf_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [isf_pkg::ELAPSED_W-1:0]  dividend,
    input  wire logic [isf_pkg::INTERVAL_W-1:0] divisor,
    output logic      [isf_pkg::ELAPSED_W-1:0]  quotient,
    output isf_pkg::div_stat_t                  stat
);

    logic [isf_pkg::ELAPSED_W-1:0]  quo_reg;
    logic [isf_pkg::INTERVAL_W-1:0] rem_reg;
    logic [4:0]                     cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [isf_pkg::INTERVAL_W:0]   rem_sh;
    logic [isf_pkg::INTERVAL_W:0]   rem_sub;
    logic                           fits;

    // Shift in the next dividend bit and try one subtract
    assign rem_sh  = {rem_reg, quo_reg[isf_pkg::ELAPSED_W-1]};
    assign rem_sub = rem_sh - {1'b0, divisor};
    assign fits    = rem_sh >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend bits leave the top of quo_reg as quotient bits enter the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[isf_pkg::ELAPSED_W-2:0], fits};
            rem_reg <= fits ? rem_sub[isf_pkg::INTERVAL_W-1:0]
                            : rem_sh[isf_pkg::INTERVAL_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
`default_nettype wire

// File: rtl/core/iso_sdu_fragmenter.sv
`timescale 1ns / 1ps
`default_nettype none
// A start byte is accepted and waits for the interval divider, then leaves as
// 9 output bytes at one per cycle when the output does not stall; a byte opening
// a new fragment leaves as 5 output bytes, any other byte as 1. No new input
// byte is taken until the last output byte of the current one is loaded.
// Reset clears the sequencer, the SDU and fragment counters and the next
// sequence number, and loads the register defaults (handle 0, 251, 5000).
// ----------------------------------------------------------------------------
// iso_sdu_fragmenter
// Builds HCI ISO data packets, byte by byte, from outgoing SDU bytes.
// ----------------------------------------------------------------------------
module iso_sdu_fragmenter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    isf_in_if.sink           in_ch,
    isf_out_if.source        out_ch
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    localparam logic [3:0] IDX_HDR  = 4'd0;
    localparam logic [3:0] IDX_HDR3 = 4'd3;
    localparam logic [3:0] IDX_DATA = 4'd8;

    isf_pkg::cfg_t      cfg;
    isf_pkg::div_stat_t div_stat;
    logic [isf_pkg::ELAPSED_W-1:0] quotient;

    logic [1:0]  state_reg, state_next;
    logic [3:0]  idx_reg;
    logic [isf_pkg::SEQ_W-1:0]     next_seq_reg;
    logic [isf_pkg::SEQ_W-1:0]     seq_reg;
    logic [isf_pkg::SDU_LEN_W-1:0] sdu_left_reg;
    logic [isf_pkg::MAXLEN_W-1:0]  frag_left_reg;
    logic [isf_pkg::SDU_LEN_W-1:0] len_reg;
    logic [isf_pkg::MAXLEN_W-1:0]  dtl_reg;
    logic [1:0]  pb_reg;
    logic [7:0]  data_reg;
    logic        pend_reg;
    logic        first_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        packet_end_reg;
    logic        last_reg;

    logic        accept;
    logic        take;
    logic        div_start;
    logic        load;
    logic [isf_pkg::MAXLEN_W-1:0]  maxlen;
    logic [isf_pkg::MAXLEN_W-1:0]  total;
    logic [isf_pkg::MAXLEN_W-1:0]  sdu_left_ext;
    logic [isf_pkg::MAXLEN_W-1:0]  dtl_new;
    logic [1:0]                    pb_new;
    logic [isf_pkg::SDU_LEN_W-1:0] sdu_base;
    logic [isf_pkg::MAXLEN_W-1:0]  frag_base;
    logic        need_hdr;
    logic [isf_pkg::SEQ_W-1:0]     ival;
    logic [isf_pkg::SEQ_W-1:0]     seq_new;
    logic [15:0] w0;
    logic [15:0] w1;
    logic [7:0]  sel_byte;

    isf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    isf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (in_ch.elapsed_us),
        .divisor  (cfg.interval),
        .quotient (quotient),
        .stat     (div_stat)
    );

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid & in_ch.ready;

    // Drop empty SDUs and bytes that arrive with no SDU open
    assign take = accept & (in_ch.sdu_start ? (in_ch.sdu_length != '0)
                                            : (sdu_left_reg != '0));
    assign div_start = take & in_ch.sdu_start;

    assign maxlen       = (cfg.max_len < isf_pkg::MAXLEN_FLOOR) ? isf_pkg::MAXLEN_FLOOR
                                                                : cfg.max_len;
    assign total        = {2'b00, in_ch.sdu_length} + isf_pkg::SDU_HDR_BYTES;
    assign sdu_left_ext = {2'b00, sdu_left_reg};
    assign need_hdr     = in_ch.sdu_start | (frag_left_reg == '0);

    always_comb
    begin
        if (in_ch.sdu_start)
        begin
            if (total <= maxlen)
            begin
                pb_new  = isf_pkg::PB_COMPLETE;
                dtl_new = total;
            end
            else
            begin
                pb_new  = isf_pkg::PB_FIRST;
                dtl_new = maxlen;
            end
            sdu_base  = in_ch.sdu_length;
            frag_base = dtl_new - isf_pkg::SDU_HDR_BYTES;
        end
        else
        begin
            if (sdu_left_ext <= maxlen)
            begin
                pb_new  = isf_pkg::PB_LAST;
                dtl_new = sdu_left_ext;
            end
            else
            begin
                pb_new  = isf_pkg::PB_CONT;
                dtl_new = maxlen;
            end
            sdu_base  = sdu_left_reg;
            frag_base = (frag_left_reg == '0) ? dtl_new : frag_left_reg;
        end
    end

    assign ival    = (cfg.interval == '0) ? '0 : quotient[isf_pkg::SEQ_W-1:0];
    assign seq_new = (next_seq_reg < ival) ? ival : next_seq_reg;

    // Output slot is free or drains this cycle
    assign load = (state_reg == ST_EMIT) & (~out_valid_reg | out_ch.ready);

    assign w0 = {2'b00, pb_reg, cfg.handle};
    assign w1 = {2'b00, dtl_reg};

    always_comb
    begin
        unique case (idx_reg)
            4'd0:    sel_byte = w0[7:0];
            4'd1:    sel_byte = w0[15:8];
            4'd2:    sel_byte = w1[7:0];
            4'd3:    sel_byte = w1[15:8];
            4'd4:    sel_byte = seq_reg[7:0];
            4'd5:    sel_byte = seq_reg[15:8];
            4'd6:    sel_byte = len_reg[7:0];
            4'd7:    sel_byte = {4'd0, len_reg[11:8]};
            4'd8:    sel_byte = data_reg;
            default: sel_byte = 8'd0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                    state_next = in_ch.sdu_start ? ST_DIV : ST_EMIT;
            end
            ST_DIV:
            begin
                if (div_stat.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (load && idx_reg == IDX_DATA)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= IDX_HDR;
            next_seq_reg  <= '0;
            sdu_left_reg  <= '0;
            frag_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take)
            begin
                sdu_left_reg  <= sdu_base - 12'd1;
                frag_left_reg <= frag_base - 14'd1;
                idx_reg       <= need_hdr ? IDX_HDR : IDX_DATA;
            end
            else if (load)
            begin
                // Skip the SDU header on continuation and last fragments
                if (idx_reg == IDX_HDR3 && !first_reg)
                    idx_reg <= IDX_DATA;
                else
                    idx_reg <= idx_reg + 4'd1;
            end
            if (state_reg == ST_DIV && div_stat.done)
                next_seq_reg <= seq_new + 16'd1;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            data_reg  <= in_ch.data_byte;
            len_reg   <= in_ch.sdu_length;
            first_reg <= in_ch.sdu_start;
            pend_reg  <= (frag_base == 14'd1);
            if (need_hdr)
            begin
                pb_reg  <= pb_new;
                dtl_reg <= dtl_new;
            end
        end
        if (state_reg == ST_DIV && div_stat.done)
            seq_reg <= seq_new;
        if (load)
        begin
            out_byte_reg   <= sel_byte;
            packet_end_reg <= (idx_reg == IDX_DATA) & pend_reg;
            last_reg       <= (idx_reg == IDX_DATA);
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.out_byte    = out_byte_reg;
    assign out_ch.packet_end  = packet_end_reg;
    assign out_ch.last_of_run = last_reg;

endmodule
`default_nettype wire
